[sv/gfd_pkg.sv]
// ----------------------------------------------------------------------------
// gfd_pkg
// Shared types and constants for the depth-limited grid flood block.
// ----------------------------------------------------------------------------
package gfd_pkg;

    // Grid store geometry
    localparam int MAX_ROWS = 64;
    localparam int MAX_COLS = 64;
    localparam int CELLS    = MAX_ROWS * MAX_COLS;

    localparam int ROW_W = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
    localparam int COL_W = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
    localparam int NR_W  = $clog2(MAX_ROWS + 1);
    localparam int NC_W  = $clog2(MAX_COLS + 1);

    // Reached map is addressed by {row, col}
    localparam int MAP_AW    = ROW_W + COL_W;
    localparam int MAP_DEPTH = 2 ** MAP_AW;

    // Frontier queue
    localparam int Q_AW    = (CELLS > 1) ? $clog2(CELLS) : 1;
    localparam int Q_CNT_W = $clog2(CELLS + 1);

    // Field widths
    localparam int DIM_W      = 7;
    localparam int LEVEL_W    = 13;
    localparam int COUNT_W    = 13;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 13;
    localparam int S_TDATA_W  = 16;
    localparam int M_TDATA_W  = 16;

    // Register reset values
    localparam logic [DIM_W-1:0]   ROWS_RESET  = 7'd64;
    localparam logic [DIM_W-1:0]   COLS_RESET  = 7'd64;
    localparam logic [LEVEL_W-1:0] LIMIT_RESET = '0;

    // Configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_GRID_ROWS  = 2'd0,
        CFG_GRID_COLS  = 2'd1,
        CFG_TIME_LIMIT = 2'd2
    } cfg_idx_t;

    // Neighbour order: up, left, down, right
    typedef enum logic [1:0] {
        DIR_UP,
        DIR_LEFT,
        DIR_DOWN,
        DIR_RIGHT
    } dir_t;

    // One frontier queue entry
    typedef struct packed {
        logic [LEVEL_W-1:0] level;
        logic [COL_W-1:0]   col;
        logic [ROW_W-1:0]   row;
    } qentry_t;

    localparam int Q_W = $bits(qentry_t);

    // Controller to datapath
    typedef struct packed {
        logic seed_load;
        logic pop;
        logic entry_latch;
        logic nb_issue;
        dir_t dir;
        logic sweep;
        logic out_load;
        logic q_clear;
    } gfd_cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic q_empty;
        logic level_ok;
        logic sweep_last;
    } gfd_status_t;

endpackage

[sv/gfd_ram.sv]
// ----------------------------------------------------------------------------
// gfd_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module gfd_ram #(
    parameter int WIDTH = 1,
    parameter int DEPTH = 2
) (
    input  logic                                     aclk,
    input  logic                                     we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                         wdata,
    input  logic                                     re,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port and registered read port; a read of the address being
    // written returns the old contents
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata <= mem[raddr];
        end
    end

endmodule

[sv/gfd_ctrl.sv]
// ----------------------------------------------------------------------------
// gfd_ctrl
// Sequencer for seed loading, breadth-first expansion and the count sweep.
// ----------------------------------------------------------------------------
module gfd_ctrl import gfd_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    input  logic        s_tlast,
    output logic        s_tready,
    output logic        m_tvalid,
    input  logic        m_tready,
    output gfd_cmd_t    cmd,
    input  gfd_status_t sts
);

    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_SEED,
        ST_POP,
        ST_ENTRY,
        ST_EXPAND,
        ST_EXPAND_END,
        ST_SWEEP,
        ST_SWEEP_END,
        ST_DONE
    } state_t;

    state_t state_reg, state_next;
    dir_t   dir_reg, dir_next;
    logic   last_reg;
    logic   s_tready_reg;
    logic   m_tvalid_reg;
    logic   accept;

    assign accept   = s_tvalid && s_tready_reg;
    assign s_tready = s_tready_reg;
    assign m_tvalid = m_tvalid_reg;

    // Next state and commands
    always_comb begin
        state_next = state_reg;
        dir_next   = dir_reg;
        cmd        = '0;
        cmd.dir    = dir_reg;
        unique case (state_reg)
            ST_CLEAR: begin
                // wipe the reached map after reset
                cmd.sweep = 1'b1;
                if (sts.sweep_last) begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (accept) begin
                    cmd.seed_load = 1'b1;
                    state_next    = ST_SEED;
                end
            end
            ST_SEED: begin
                // map lookup of the seed completes here
                state_next = last_reg ? ST_POP : ST_IDLE;
            end
            ST_POP: begin
                if (sts.q_empty) begin
                    state_next = ST_SWEEP;
                end else begin
                    cmd.pop    = 1'b1;
                    state_next = ST_ENTRY;
                end
            end
            ST_ENTRY: begin
                if (sts.level_ok) begin
                    cmd.entry_latch = 1'b1;
                    dir_next        = DIR_UP;
                    state_next      = ST_EXPAND;
                end else begin
                    state_next = ST_SWEEP;
                end
            end
            ST_EXPAND: begin
                cmd.nb_issue = 1'b1;
                if (dir_reg == DIR_RIGHT) begin
                    state_next = ST_EXPAND_END;
                end else begin
                    dir_next = dir_t'(dir_reg + 2'd1);
                end
            end
            ST_EXPAND_END: begin
                // last neighbour is checked in this cycle
                state_next = ST_POP;
            end
            ST_SWEEP: begin
                cmd.sweep = 1'b1;
                if (sts.sweep_last) begin
                    state_next = ST_SWEEP_END;
                end
            end
            ST_SWEEP_END: begin
                state_next = ST_DONE;
            end
            ST_DONE: begin
                if (!m_tvalid_reg || m_tready) begin
                    cmd.out_load = 1'b1;
                    cmd.q_clear  = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_CLEAR;
            end
        endcase
    end

    // State and registered handshake outputs
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_CLEAR;
            dir_reg      <= DIR_UP;
            last_reg     <= 1'b0;
            s_tready_reg <= 1'b0;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            dir_reg      <= dir_next;
            s_tready_reg <= (state_next == ST_IDLE);
            if (accept) begin
                last_reg <= s_tlast;
            end
            if (cmd.out_load) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

endmodule

[sv/gfd_datapath.sv]
// ----------------------------------------------------------------------------
// gfd_datapath
// Configuration registers, reached map, frontier queue and count sweep.
// ----------------------------------------------------------------------------
module gfd_datapath import gfd_pkg::*; (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    input  logic [DIM_W-1:0]      seed_row,
    input  logic [DIM_W-1:0]      seed_col,
    input  gfd_cmd_t              cmd,
    output gfd_status_t           sts,
    output logic [COUNT_W-1:0]    unreached_count
);

    // Configuration
    logic [DIM_W-1:0]   rows_reg;
    logic [DIM_W-1:0]   cols_reg;
    logic [LEVEL_W-1:0] limit_reg;
    logic [NR_W-1:0]    nr;
    logic [NC_W-1:0]    nc;

    // Seed decode
    logic               seed_ok;
    logic [ROW_W-1:0]   seed_r;
    logic [COL_W-1:0]   seed_c;

    // Entry being expanded and its neighbour
    logic [ROW_W-1:0]   e_row_reg;
    logic [COL_W-1:0]   e_col_reg;
    logic [LEVEL_W-1:0] e_level_reg;
    logic               nb_step_ok;
    logic               nb_ok;
    logic [ROW_W-1:0]   nb_row;
    logic [COL_W-1:0]   nb_col;

    // Cell awaiting its map lookup
    logic               pend_valid_reg;
    logic [ROW_W-1:0]   pend_row_reg;
    logic [COL_W-1:0]   pend_col_reg;
    logic [LEVEL_W-1:0] pend_level_reg;
    logic               enq;

    // Queue pointers
    logic [Q_CNT_W-1:0] head_reg;
    logic [Q_CNT_W-1:0] tail_reg;
    qentry_t            q_wdata;
    qentry_t            q_rdata;

    // Sweep
    logic [MAP_AW-1:0]  swp_addr_reg;
    logic               swp_chk_reg;
    logic [MAP_AW-1:0]  swp_prev_reg;
    logic               swp_in_grid;
    logic [COUNT_W-1:0] count_reg;
    logic [COUNT_W-1:0] out_reg;

    // Map ports
    logic               map_we;
    logic [MAP_AW-1:0]  map_waddr;
    logic               map_wdata;
    logic               map_re;
    logic [MAP_AW-1:0]  map_raddr;
    logic               map_rdata;

    // Configuration writes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rows_reg  <= ROWS_RESET;
            cols_reg  <= COLS_RESET;
            limit_reg <= LIMIT_RESET;
        end else if (cfg_we) begin
            unique case (cfg_index)
                CFG_GRID_ROWS:  rows_reg  <= cfg_data[DIM_W-1:0];
                CFG_GRID_COLS:  cols_reg  <= cfg_data[DIM_W-1:0];
                CFG_TIME_LIMIT: limit_reg <= cfg_data[LEVEL_W-1:0];
                default: ;
            endcase
        end
    end

    // Grid size in use, clamped to the store
    assign nr = (int'(rows_reg) > MAX_ROWS) ? NR_W'(MAX_ROWS) : NR_W'(rows_reg);
    assign nc = (int'(cols_reg) > MAX_COLS) ? NC_W'(MAX_COLS) : NC_W'(cols_reg);

    // Seed is 1-based; zero or beyond the grid is dropped
    assign seed_ok = (seed_row != '0) && (seed_col != '0)
                  && (int'(seed_row) <= int'(nr)) && (int'(seed_col) <= int'(nc));
    assign seed_r  = ROW_W'(seed_row - DIM_W'(1));
    assign seed_c  = COL_W'(seed_col - DIM_W'(1));

    // Neighbour of the current entry; the step itself must not wrap
    always_comb begin
        nb_step_ok = 1'b0;
        nb_row     = e_row_reg;
        nb_col     = e_col_reg;
        unique case (cmd.dir)
            DIR_UP: begin
                nb_step_ok = (e_row_reg != '0);
                nb_row     = e_row_reg - ROW_W'(1);
            end
            DIR_LEFT: begin
                nb_step_ok = (e_col_reg != '0);
                nb_col     = e_col_reg - COL_W'(1);
            end
            DIR_DOWN: begin
                nb_step_ok = (int'(e_row_reg) + 1 < int'(nr));
                nb_row     = e_row_reg + ROW_W'(1);
            end
            DIR_RIGHT: begin
                nb_step_ok = (int'(e_col_reg) + 1 < int'(nc));
                nb_col     = e_col_reg + COL_W'(1);
            end
            default: begin
                nb_step_ok = 1'b0;
            end
        endcase
    end

    // Both coordinates must lie in the grid in use; an entry queued before
    // the grid shrank may sit outside it
    assign nb_ok = nb_step_ok && (int'(nb_row) < int'(nr)) && (int'(nb_col) < int'(nc));

    // Pending lookup: a seed or a neighbour, checked the cycle after
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pend_valid_reg <= 1'b0;
        end else begin
            pend_valid_reg <= (cmd.seed_load && seed_ok) || (cmd.nb_issue && nb_ok);
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.seed_load) begin
            pend_row_reg   <= seed_r;
            pend_col_reg   <= seed_c;
            pend_level_reg <= '0;
        end else if (cmd.nb_issue) begin
            pend_row_reg   <= nb_row;
            pend_col_reg   <= nb_col;
            pend_level_reg <= e_level_reg + LEVEL_W'(1);
        end
    end

    // Unreached cell: mark it and queue it
    assign enq = pend_valid_reg && !map_rdata;

    // Map access
    always_comb begin
        map_re    = cmd.seed_load || cmd.nb_issue || cmd.sweep;
        map_raddr = swp_addr_reg;
        if (cmd.seed_load) begin
            map_raddr = {seed_r, seed_c};
        end else if (cmd.nb_issue) begin
            map_raddr = {nb_row, nb_col};
        end
        map_we    = enq || cmd.sweep;
        map_wdata = enq;
        map_waddr = enq ? {pend_row_reg, pend_col_reg} : swp_addr_reg;
    end

    gfd_ram #(
        .WIDTH (1),
        .DEPTH (MAP_DEPTH)
    ) u_map (
        .aclk  (aclk),
        .we    (map_we),
        .waddr (map_waddr),
        .wdata (map_wdata),
        .re    (map_re),
        .raddr (map_raddr),
        .rdata (map_rdata)
    );

    // Frontier queue
    assign q_wdata.level = pend_level_reg;
    assign q_wdata.col   = pend_col_reg;
    assign q_wdata.row   = pend_row_reg;

    gfd_ram #(
        .WIDTH (Q_W),
        .DEPTH (CELLS)
    ) u_queue (
        .aclk  (aclk),
        .we    (enq),
        .waddr (tail_reg[Q_AW-1:0]),
        .wdata (q_wdata),
        .re    (cmd.pop),
        .raddr (head_reg[Q_AW-1:0]),
        .rdata (q_rdata)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            head_reg <= '0;
            tail_reg <= '0;
        end else if (cmd.q_clear) begin
            head_reg <= '0;
            tail_reg <= '0;
        end else begin
            if (cmd.pop) begin
                head_reg <= head_reg + Q_CNT_W'(1);
            end
            if (enq) begin
                tail_reg <= tail_reg + Q_CNT_W'(1);
            end
        end
    end

    // Latch the popped entry
    always_ff @(posedge aclk) begin
        if (cmd.entry_latch) begin
            e_row_reg   <= q_rdata.row;
            e_col_reg   <= q_rdata.col;
            e_level_reg <= q_rdata.level;
        end
    end

    // Sweep: read and clear one cell a cycle, count on the returned data
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            swp_addr_reg <= '0;
            swp_chk_reg  <= 1'b0;
        end else begin
            swp_chk_reg <= cmd.sweep;
            if (cmd.sweep) begin
                swp_addr_reg <= swp_addr_reg + MAP_AW'(1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        swp_prev_reg <= swp_addr_reg;
    end

    assign swp_in_grid = (int'(swp_prev_reg[MAP_AW-1:COL_W]) < int'(nr))
                      && (int'(swp_prev_reg[COL_W-1:0]) < int'(nc));

    always_ff @(posedge aclk) begin
        if (cmd.sweep && (swp_addr_reg == '0)) begin
            count_reg <= '0;
        end else if (swp_chk_reg && swp_in_grid && !map_rdata) begin
            count_reg <= count_reg + COUNT_W'(1);
        end
    end

    // Result register
    always_ff @(posedge aclk) begin
        if (cmd.out_load) begin
            out_reg <= count_reg;
        end
    end

    assign unreached_count = out_reg;

    // Status
    assign sts.q_empty    = (head_reg == tail_reg);
    assign sts.level_ok   = (q_rdata.level < limit_reg);
    assign sts.sweep_last = (swp_addr_reg == {MAP_AW{1'b1}});

endmodule

[sv/grid_flood_depth_limited.sv]
// ----------------------------------------------------------------------------
// grid_flood_depth_limited
// Depth-limited multi-source breadth-first flood over a configurable grid.
// ----------------------------------------------------------------------------
// Seeds arrive as 1-based (row, column) pairs, one per transaction; a seed
// outside the grid in use is dropped. Each seed is accepted and then looked
// up in the reached map before the next is taken. The transaction with
// s_tlast set starts the flood: every queued cell below time_limit is
// expanded to its four neighbours, one dequeued cell at a time (queue read,
// latch, four map lookups, one final check), the map's single read port
// being the limit. A sweep over all MAP_DEPTH map addresses then counts the
// unreached cells and clears the map for the next run. After reset the map
// is cleared by the same sweep, during which no seed is taken; configuration
// writes are accepted at any time but must only be made while the block is
// idle. The result waits in an output register, and seeds of the next run
// are accepted while it does.
// ----------------------------------------------------------------------------
module grid_flood_depth_limited import gfd_pkg::*; (
    input  logic                  aclk,
    input  logic                  aresetn,
    // Seed stream
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [S_TDATA_W-1:0]  s_tdata,   // [6:0] seed_row, [13:7] seed_col
    input  logic                  s_tlast,   // last_seed
    // Result stream
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [M_TDATA_W-1:0]  m_tdata,   // [12:0] unreached_count
    // Configuration writes
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    gfd_cmd_t           cmd;
    gfd_status_t        sts;
    logic [COUNT_W-1:0] unreached_count;

    assign cfg_ready = 1'b1;
    assign m_tdata   = M_TDATA_W'(unreached_count);

    gfd_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tlast  (s_tlast),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .cmd      (cmd),
        .sts      (sts)
    );

    gfd_datapath u_datapath (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cfg_we          (cfg_valid),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data),
        .seed_row        (s_tdata[DIM_W-1:0]),
        .seed_col        (s_tdata[2*DIM_W-1:DIM_W]),
        .cmd             (cmd),
        .sts             (sts),
        .unreached_count (unreached_count)
    );

endmodule

[sv/gfd_checker.sv]
// ----------------------------------------------------------------------------
// gfd_checker
// Port-level checks on the grid flood block, bound to the top level.
// ----------------------------------------------------------------------------
module gfd_checker import gfd_pkg::*; (
    input logic                  aclk,
    input logic                  aresetn,
    input logic                  s_tvalid,
    input logic                  s_tready,
    input logic                  s_tlast,
    input logic                  m_tvalid,
    input logic                  m_tready,
    input logic [M_TDATA_W-1:0]  m_tdata
);

    // Stalled result holds
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata)))
        else $error("result transaction changed while stalled");

    // Each seed needs its map lookup before the next is taken
    assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |=> !s_tready)
        else $error("seed taken back to back");

    // Final seed starts the flood; the seed input must not reopen at once
    assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready && s_tlast) |=> !s_tready ##1 !s_tready ##1 !s_tready)
        else $error("seed input reopened during flood");

    // A result is only produced at the end of a flood, never from idle
    assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_tvalid) |-> $past(!s_tready))
        else $error("result appeared while idle");

endmodule

bind grid_flood_depth_limited gfd_checker u_gfd_checker (.*);

[tb/tb_grid_flood_depth_limited.sv]
// ----------------------------------------------------------------------------
// tb_grid_flood_depth_limited
// Self-checking testbench for the depth-limited grid flood block.
// ----------------------------------------------------------------------------
// Seeds are pushed through the input stream and every run-closing seed
// yields one unreached-cell count. A cycle-free predictor follows each
// accepted seed and configuration write and queues the count it expects.
// A short directed table covers the grid extremes, oversized and zero grid
// sizes, repeated seeds and a resize in the middle of a run. Random runs
// follow, mostly of well-formed seeds on small grids, under three idling
// patterns, one long result back-pressure stretch and one full drain.
// ----------------------------------------------------------------------------
module tb_grid_flood_depth_limited;
    timeunit 1ns;
    timeprecision 1ps;

    import gfd_pkg::*;

    localparam int RANDOM_ITEMS   = 80;
    localparam int SETTLE_CYCLES  = 16;
    localparam int HOLD_CYCLES    = 20000;
    localparam int QUIET_LIMIT    = 200000;

    // Idling patterns of the two streams
    typedef enum int {
        IDLE_MIXED,     // sender 31 %, receiver 45 %
        IDLE_SWAPPED,   // sender 45 %, receiver 31 %
        IDLE_NONE
    } idle_mode_t;

    // One row of the directed table
    typedef struct packed {
        logic                 wr;       // rewrite all registers before this seed
        logic [DIM_W-1:0]     rows;
        logic [DIM_W-1:0]     cols;
        logic [LEVEL_W-1:0]   limit;
        logic [DIM_W-1:0]     row;
        logic [DIM_W-1:0]     col;
        logic                 last;
        logic                 known;    // count typed in below
        logic [COUNT_W-1:0]   count;
    } plan_row_t;

    localparam int PLAN_LEN = 20;
    localparam plan_row_t PLAN [PLAN_LEN] = '{
        // reset sizes, no spreading
        '{1'b0, 7'd0,   7'd0,   13'd0,    7'd0,   7'd0,   1'b1, 1'b1, 13'd4096},
        '{1'b0, 7'd0,   7'd0,   13'd0,    7'd64,  7'd64,  1'b1, 1'b1, 13'd4095},
        '{1'b0, 7'd0,   7'd0,   13'd0,    7'd65,  7'd1,   1'b1, 1'b1, 13'd4096},
        // oversized registers clamp to the store size
        '{1'b1, 7'd127, 7'd127, 13'd0,    7'd127, 7'd127, 1'b1, 1'b1, 13'd4096},
        '{1'b0, 7'd0,   7'd0,   13'd0,    7'd64,  7'd64,  1'b1, 1'b1, 13'd4095},
        '{1'b0, 7'd0,   7'd0,   13'd0,    7'd1,   7'd0,   1'b1, 1'b1, 13'd4096},
        // empty grid in either dimension
        '{1'b1, 7'd0,   7'd5,   13'd3,    7'd1,   7'd1,   1'b1, 1'b1, 13'd0},
        '{1'b1, 7'd5,   7'd0,   13'd3,    7'd1,   7'd1,   1'b1, 1'b1, 13'd0},
        // repeated seed in one run
        '{1'b1, 7'd4,   7'd4,   13'd1,    7'd1,   7'd1,   1'b0, 1'b0, 13'd0},
        '{1'b0, 7'd0,   7'd0,   13'd0,    7'd1,   7'd1,   1'b0, 1'b0, 13'd0},
        '{1'b0, 7'd0,   7'd0,   13'd0,    7'd4,   7'd4,   1'b1, 1'b0, 13'd0},
        // single cell, deepest limit
        '{1'b1, 7'd1,   7'd1,   13'd8191, 7'd1,   7'd1,   1'b1, 1'b1, 13'd0},
        // grid shrunk while the run is open
        '{1'b1, 7'd8,   7'd8,   13'd2,    7'd3,   7'd3,   1'b0, 1'b0, 13'd0},
        '{1'b0, 7'd0,   7'd0,   13'd0,    7'd8,   7'd1,   1'b0, 1'b0, 13'd0},
        '{1'b1, 7'd3,   7'd3,   13'd2,    7'd0,   7'd5,   1'b1, 1'b0, 13'd0},
        // whole store flooded
        '{1'b1, 7'd64,  7'd64,  13'd8191, 7'd32,  7'd32,  1'b1, 1'b1, 13'd0},
        // thin grid, out-of-range seeds on both axes
        '{1'b1, 7'd2,   7'd64,  13'd3,    7'd2,   7'd127, 1'b0, 1'b0, 13'd0},
        '{1'b0, 7'd0,   7'd0,   13'd0,    7'd127, 7'd2,   1'b0, 1'b0, 13'd0},
        '{1'b0, 7'd0,   7'd0,   13'd0,    7'd1,   7'd64,  1'b1, 1'b0, 13'd0},
        '{1'b1, 7'd9,   7'd6,   13'd0,    7'd9,   7'd6,   1'b1, 1'b1, 13'd53}
    };

    // Clock, reset and ports
    logic                  aclk      = 1'b0;
    logic                  aresetn   = 1'b0;
    logic                  s_tvalid  = 1'b0;
    logic                  s_tready;
    logic [S_TDATA_W-1:0]  s_tdata   = '0;   // [6:0] seed_row, [13:7] seed_col
    logic                  s_tlast   = 1'b0; // last_seed
    logic                  m_tvalid;
    logic                  m_tready  = 1'b0;
    logic [M_TDATA_W-1:0]  m_tdata;          // [12:0] unreached_count
    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data  = '0;

    always #1 aclk = ~aclk;

    grid_flood_depth_limited DUT (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tlast   (s_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // Shared run state
    idle_mode_t         phase         = IDLE_MIXED;
    int                 hold_requests = 0;
    int                 mismatches    = 0;
    logic [COUNT_W-1:0] pending_counts [$];

    // ------------------------------------------------------------------------
    // Predictor: shadow registers, reached map and frontier
    // ------------------------------------------------------------------------
    typedef struct {
        int          r;
        int          c;
        int unsigned lvl;
    } frontier_cell_t;

    logic [DIM_W-1:0]   sh_rows  = ROWS_RESET;
    logic [DIM_W-1:0]   sh_cols  = COLS_RESET;
    logic [LEVEL_W-1:0] sh_limit = LIMIT_RESET;
    bit                 reached_cells [MAX_ROWS][MAX_COLS];
    frontier_cell_t     frontier [$];
    bit                 run_started = 1'b0;

    function automatic int rows_in_use();
        return (sh_rows > MAX_ROWS) ? MAX_ROWS : int'(sh_rows);
    endfunction

    function automatic int cols_in_use();
        return (sh_cols > MAX_COLS) ? MAX_COLS : int'(sh_cols);
    endfunction

    function automatic void mark_cell(input int r, input int c, input int unsigned lvl);
        frontier_cell_t node;
        if (!reached_cells[r][c]) begin
            reached_cells[r][c] = 1'b1;
            node.r   = r;
            node.c   = c;
            node.lvl = lvl;
            frontier.push_back(node);
        end
    endfunction

    // Spread from the frontier, then count the cells left untouched
    function automatic logic [COUNT_W-1:0] flood_unreached();
        int             nr;
        int             nc;
        int             rr;
        int             cc;
        int unsigned    total;
        frontier_cell_t node;
        nr    = rows_in_use();
        nc    = cols_in_use();
        total = 0;
        while (frontier.size() != 0 && frontier[0].lvl < sh_limit) begin
            node = frontier.pop_front();
            for (int d = 0; d < 4; d++) begin
                rr = node.r;
                cc = node.c;
                case (dir_t'(d))
                    DIR_UP:   rr = rr - 1;
                    DIR_LEFT: cc = cc - 1;
                    DIR_DOWN: rr = rr + 1;
                    default:  cc = cc + 1;
                endcase
                if (rr >= 0 && cc >= 0 && rr < nr && cc < nc)
                    mark_cell(rr, cc, node.lvl + 1);
            end
        end
        for (int r = 0; r < nr; r++)
            for (int c = 0; c < nc; c++)
                if (!reached_cells[r][c])
                    total++;
        return total[COUNT_W-1:0];
    endfunction

    function automatic void apply_seed(input logic [DIM_W-1:0] row,
                                       input logic [DIM_W-1:0] col,
                                       input logic last,
                                       output bit fired,
                                       output logic [COUNT_W-1:0] unreached);
        fired     = 1'b0;
        unreached = '0;
        // first seed of a run starts from a clean map
        if (!run_started) begin
            foreach (reached_cells[r, c])
                reached_cells[r][c] = 1'b0;
            frontier.delete();
            run_started = 1'b1;
        end
        if (row >= 1 && col >= 1 && row <= rows_in_use() && col <= cols_in_use())
            mark_cell(row - 1, col - 1, 0);
        if (last) begin
            unreached   = flood_unreached();
            fired       = 1'b1;
            run_started = 1'b0;
        end
    endfunction

    function automatic int unsigned send_gap_pct();
        case (phase)
            IDLE_MIXED:   return 31;
            IDLE_SWAPPED: return 45;
            default:      return 0;
        endcase
    endfunction

    function automatic int unsigned recv_gap_pct();
        case (phase)
            IDLE_MIXED:   return 45;
            IDLE_SWAPPED: return 31;
            default:      return 0;
        endcase
    endfunction

    // ------------------------------------------------------------------------
    // Drivers
    // ------------------------------------------------------------------------
    task automatic send_seed(input logic [DIM_W-1:0] row, input logic [DIM_W-1:0] col,
                             input logic last, input bit typed,
                             input logic [COUNT_W-1:0] typed_count);
        bit                 fired;
        logic [COUNT_W-1:0] unreached;
        while ($urandom_range(99) < send_gap_pct()) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= S_TDATA_W'({col, row});
        s_tlast  <= last;
        do @(posedge aclk); while (!s_tready);
        apply_seed(row, col, last, fired, unreached);
        if (fired)
            pending_counts.push_back(typed ? typed_count : unreached);
    endtask

    // All three registers in one burst, valid held high throughout
    task automatic write_grid_config(input logic [DIM_W-1:0] rows,
                                     input logic [DIM_W-1:0] cols,
                                     input logic [LEVEL_W-1:0] limit);
        cfg_idx_t              idx;
        logic [CFG_DATA_W-1:0] value;
        for (int i = 0; i < 3; i++) begin
            idx = cfg_idx_t'(i);
            case (idx)
                CFG_GRID_ROWS: value = CFG_DATA_W'(rows);
                CFG_GRID_COLS: value = CFG_DATA_W'(cols);
                default:       value = CFG_DATA_W'(limit);
            endcase
            cfg_valid <= 1'b1;
            cfg_index <= idx;
            cfg_data  <= value;
            do @(posedge aclk); while (!cfg_ready);
            case (idx)
                CFG_GRID_ROWS: sh_rows  = value[DIM_W-1:0];
                CFG_GRID_COLS: sh_cols  = value[DIM_W-1:0];
                default:       sh_limit = value[LEVEL_W-1:0];
            endcase
        end
        cfg_valid <= 1'b0;
    endtask

    // Stop offering seeds, wait for every count, then let the block go quiet
    task automatic drain_and_settle();
        s_tvalid <= 1'b0;
        while (pending_counts.size() != 0)
            @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    // ------------------------------------------------------------------------
    // Result receiver: random stalls plus requested long hold-offs
    // ------------------------------------------------------------------------
    initial begin
        int hold_served;
        int hold_left;
        hold_served = 0;
        hold_left   = 0;
        forever begin
            @(posedge aclk);
            if (hold_left == 0 && hold_served != hold_requests) begin
                hold_left   = HOLD_CYCLES;
                hold_served = hold_served + 1;
            end
            if (hold_left > 0) begin
                hold_left = hold_left - 1;
                m_tready <= 1'b0;
            end else begin
                m_tready <= ($urandom_range(99) >= recv_gap_pct());
            end
        end
    end

    // ------------------------------------------------------------------------
    // Result checker and watchdog
    // ------------------------------------------------------------------------
    int quiet_cycles = 0;

    always @(posedge aclk) begin
        logic [COUNT_W-1:0] want;
        if (aresetn) begin
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
                quiet_cycles = 0;
            else
                quiet_cycles = quiet_cycles + 1;

            if (m_tvalid && m_tready) begin
                if (pending_counts.size() == 0) begin
                    mismatches = mismatches + 1;
                    $display("%0t: result with no count pending, actual %0d",
                             $realtime, m_tdata);
                end else begin
                    want = pending_counts.pop_front();
                    if (m_tdata !== M_TDATA_W'(want)) begin
                        mismatches = mismatches + 1;
                        $display("%0t: unreached_count mismatch, expected %0d actual %0d",
                                 $realtime, want, m_tdata);
                    end
                end
            end

            if (quiet_cycles >= QUIET_LIMIT) begin
                $display("%0t: no transaction for %0d cycles", $realtime, QUIET_LIMIT);
                $display("[FAIL] regression broken");
                $finish;
            end
        end
    end

    // ------------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------------
    initial begin
        int               items_sent;
        int               run_len;
        int               burst_left;
        int               roll;
        int               nr;
        int               nc;
        bit               hold_issued;
        bit               drain_done;
        bit               have_prev;
        logic [DIM_W-1:0] row;
        logic [DIM_W-1:0] col;
        logic [DIM_W-1:0] prev_row;
        logic [DIM_W-1:0] prev_col;
        logic [DIM_W-1:0] new_rows;
        logic [DIM_W-1:0] new_cols;
        logic [LEVEL_W-1:0] new_limit;
        logic             last;

        items_sent  = 0;
        burst_left  = 0;
        hold_issued = 1'b0;
        drain_done  = 1'b0;
        have_prev   = 1'b0;
        prev_row    = '0;
        prev_col    = '0;

        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed table
        phase = IDLE_MIXED;
        foreach (PLAN[i]) begin
            if (PLAN[i].wr) begin
                drain_and_settle();
                write_grid_config(PLAN[i].rows, PLAN[i].cols, PLAN[i].limit);
            end
            send_seed(PLAN[i].row, PLAN[i].col, PLAN[i].last, PLAN[i].known, PLAN[i].count);
        end

        // Random runs
        while (items_sent < RANDOM_ITEMS) begin
            if (items_sent < RANDOM_ITEMS / 3)
                phase = IDLE_MIXED;
            else if (items_sent < 2 * RANDOM_ITEMS / 3)
                phase = IDLE_SWAPPED;
            else
                phase = IDLE_NONE;

            // back-pressure burst: short runs while the receiver holds off
            if (!hold_issued && items_sent >= 30) begin
                hold_issued   = 1'b1;
                hold_requests = hold_requests + 1;
                burst_left    = 3;
            end else if (!drain_done && items_sent >= 70) begin
                drain_done = 1'b1;
                drain_and_settle();
            end

            if (burst_left > 0) begin
                burst_left = burst_left - 1;
                run_len    = 2;
            end else begin
                if ($urandom_range(99) < 60) begin
                    roll = $urandom_range(99);
                    new_rows = (roll < 3)  ? 7'd0 :
                               (roll < 85) ? DIM_W'($urandom_range(1, 12)) :
                               (roll < 93) ? DIM_W'($urandom_range(13, 64)) :
                                             DIM_W'($urandom_range(65, 127));
                    roll = $urandom_range(99);
                    new_cols = (roll < 3)  ? 7'd0 :
                               (roll < 85) ? DIM_W'($urandom_range(1, 12)) :
                               (roll < 93) ? DIM_W'($urandom_range(13, 64)) :
                                             DIM_W'($urandom_range(65, 127));
                    roll = $urandom_range(99);
                    new_limit = (roll < 50) ? LEVEL_W'($urandom_range(0, 6)) :
                                (roll < 90) ? LEVEL_W'($urandom_range(7, 40)) :
                                              LEVEL_W'($urandom_range(41, 8191));
                    drain_and_settle();
                    write_grid_config(new_rows, new_cols, new_limit);
                    have_prev = 1'b0;
                end
                run_len = $urandom_range(1, 6);
            end

            nr = rows_in_use();
            nc = cols_in_use();
            for (int k = 0; k < run_len; k++) begin
                roll = $urandom_range(99);
                if (roll < 6 && have_prev) begin
                    row = prev_row;
                    col = prev_col;
                end else if (roll < 86 && nr > 0 && nc > 0) begin
                    row = DIM_W'($urandom_range(1, nr));
                    col = DIM_W'($urandom_range(1, nc));
                end else begin
                    row = DIM_W'($urandom_range(127));
                    col = DIM_W'($urandom_range(127));
                end
                last = (k == run_len - 1);
                items_sent = items_sent + 1;
                send_seed(row, col, last, 1'b0, '0);
                prev_row  = row;
                prev_col  = col;
                have_prev = 1'b1;
            end
        end

        drain_and_settle();
        if (mismatches == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule
